// File: sv/afs_pkg.sv
// ----------------------------------------------------------------------------
// Animation frame sequencer package
// Shared operation codes, configuration register indexes and field widths.
// ----------------------------------------------------------------------------
package afs_pkg;

    // Widths of the item fields and of the configuration port.
    localparam int OP_W      = 2;
    localparam int FIDX_W    = 6;
    localparam int HOLD_W    = 16;
    localparam int COUNT_W   = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    // Reset value of the default hold interval.
    localparam logic [HOLD_W-1:0] DEFAULT_INTERVAL_RST = 16'd4;

    // Operation carried by an input item.
    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 2'd0,
        OP_SET     = 2'd1,
        OP_WRITE   = 2'd2,
        OP_RESTART = 2'd3
    } afs_op_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_PLAYBACK = 2'd2;

endpackage

// File: sv/animation_frame_sequencer.sv
// ----------------------------------------------------------------------------
// Animation frame sequencer
// Steps an animation through its frames, holding each for its own interval.
// ----------------------------------------------------------------------------
// Usage:
// Each input item on the s_ channel is a tick, a set of the play index, a
// write of one frame's hold interval, or a restart at frame 0. Every item
// gives exactly one result item on the m_ channel, carrying the frame shown,
// whether a tick showed a frame, the play index after the step and the
// finished flag.
// m_valid rises in the cycle after acceptance, and one item is accepted in
// every cycle while the result register is empty or being drained; the limit
// is the single result register, with the interval table read ahead from the
// next play position. When the receiver stalls, the result is held and
// s_ready falls until it is taken. Synchronous reset clears the play
// position, hold counter, written flags and the result register, and
// restores the configuration registers. The configuration port writes
// frame_count, default_interval and reverse_playback by index; the user
// must use it only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module animation_frame_sequencer #(
    parameter int MAX_FRAMES = 64,
    parameter int TICK_BITS  = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration port
    input  logic                           cfg_wen,
    input  logic [afs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [afs_pkg::CFG_W-1:0]      cfg_wdata,
    // Input channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [afs_pkg::OP_W-1:0]       s_op,
    input  logic [afs_pkg::FIDX_W-1:0]     s_frame_index,
    input  logic [afs_pkg::HOLD_W-1:0]     s_hold_ticks,
    // Result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [afs_pkg::FIDX_W-1:0]     m_shown_frame,
    output logic                           m_shown_valid,
    output logic [afs_pkg::COUNT_W-1:0]    m_play_index,
    output logic                           m_finished
);

    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CMP_W = (TICK_BITS > afs_pkg::HOLD_W) ? TICK_BITS : afs_pkg::HOLD_W;
    localparam int CW    = afs_pkg::COUNT_W;
    localparam logic [CW-1:0] MAX_FRAMES_C = CW'(MAX_FRAMES);

    // Clamp the frame count register to the table depth.
    function automatic logic [CW-1:0] eff_count(input logic [CW-1:0] fc);
        logic [CW-1:0] c;
        c = (32'(fc) > 32'(MAX_FRAMES)) ? MAX_FRAMES_C : fc;
        return c;
    endfunction

    // Frame shown for a play position, mirrored when playing backwards and
    // clamped to the frame range. The count must be nonzero.
    function automatic logic [CW-1:0] shown_of(input logic [CW-1:0] pos,
                                               input logic [CW-1:0] c,
                                               input logic          rev);
        logic [CW-1:0] s;
        if (rev) begin
            s = (pos >= c) ? '0 : (c - CW'(1) - pos);
        end else begin
            s = (pos >= c) ? (c - CW'(1)) : pos;
        end
        return s;
    endfunction

    // Table address from a frame number that is known to be in range.
    function automatic logic [IDX_W-1:0] to_addr(input logic [CW-1:0] v);
        logic [IDX_W+CW-1:0] w;
        w = {{IDX_W{1'b0}}, v};
        return w[IDX_W-1:0];
    endfunction

    // Configuration registers
    logic [CW-1:0]                 frame_count_reg, frame_count_next;
    logic [afs_pkg::HOLD_W-1:0]    default_interval_reg;
    logic                          reverse_reg, reverse_next;

    // Sequencer state
    logic [CW-1:0]                 play_pos_reg, play_pos_next;
    logic [TICK_BITS-1:0]          hold_reg, hold_next;
    logic [afs_pkg::FIDX_W-1:0]    last_shown_reg, last_shown_next;
    logic [MAX_FRAMES-1:0]         written_reg;

    // Result register
    logic                          m_valid_reg;
    logic [afs_pkg::FIDX_W-1:0]    m_shown_frame_reg;
    logic                          m_shown_valid_reg, shown_valid_next;
    logic [CW-1:0]                 m_play_index_reg;
    logic                          m_finished_reg;

    // Interval table and its read-ahead path
    logic                          ram_we;
    logic [IDX_W-1:0]              ram_waddr, ram_raddr;
    logic [afs_pkg::HOLD_W-1:0]    ram_rdata;
    logic                          bypass_hit_reg;
    logic [afs_pkg::HOLD_W-1:0]    bypass_data_reg;

    logic                          accept;
    afs_pkg::afs_op_t              op;
    logic [CW-1:0]                 count_now, count_next, sel_now, sel_ahead;
    logic [CW-1:0]                 fidx_ext, pos_adv, hold_zero;
    logic [afs_pkg::HOLD_W-1:0]    interval;
    logic [TICK_BITS-1:0]          hold_base;
    logic                          write_ok;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign op        = afs_pkg::afs_op_t'(s_op);
    assign fidx_ext  = {1'b0, s_frame_index};
    assign count_now = eff_count(frame_count_reg);
    assign sel_now   = shown_of(play_pos_reg, count_now, reverse_reg);
    assign write_ok  = 32'(s_frame_index) < 32'(MAX_FRAMES);
    assign pos_adv   = (play_pos_reg < count_now) ? (play_pos_reg + CW'(1)) : play_pos_reg;
    assign hold_zero = '0;

    // The table entry for the current position was read in the previous
    // cycle; a write to that same entry in that cycle is forwarded.
    assign interval = written_reg[to_addr(sel_now)] ?
                      (bypass_hit_reg ? bypass_data_reg : ram_rdata) :
                      default_interval_reg;

    // Configuration next values, used for the table read-ahead.
    always_comb begin
        frame_count_next = frame_count_reg;
        reverse_next     = reverse_reg;
        if (cfg_wen && cfg_index == afs_pkg::CFG_FRAME_COUNT) begin
            frame_count_next = cfg_wdata[CW-1:0];
        end
        if (cfg_wen && cfg_index == afs_pkg::CFG_REVERSE_PLAYBACK) begin
            reverse_next = cfg_wdata[0];
        end
    end

    // Step logic for one accepted item.
    always_comb begin
        play_pos_next    = play_pos_reg;
        hold_next        = hold_reg;
        last_shown_next  = last_shown_reg;
        shown_valid_next = 1'b0;
        ram_we           = 1'b0;
        hold_base        = hold_reg;
        if (accept) begin
            unique case (op)
                afs_pkg::OP_TICK: begin
                    if (count_now != '0) begin
                        if (CMP_W'(hold_reg) >= CMP_W'(interval)) begin
                            play_pos_next = pos_adv;
                            hold_base     = '0;
                        end
                        hold_next        = (hold_base != '1) ? (hold_base + TICK_BITS'(1))
                                                             : hold_base;
                        last_shown_next  = sel_now[afs_pkg::FIDX_W-1:0];
                        shown_valid_next = 1'b1;
                    end
                end
                afs_pkg::OP_SET: begin
                    if (count_now == '0) begin
                        play_pos_next = hold_zero;
                    end else if (fidx_ext >= count_now) begin
                        play_pos_next = count_now - CW'(1);
                    end else begin
                        play_pos_next = fidx_ext;
                    end
                    hold_next       = '0;
                    last_shown_next = '0;
                end
                afs_pkg::OP_WRITE: begin
                    ram_we = write_ok;
                end
                afs_pkg::OP_RESTART: begin
                    play_pos_next   = '0;
                    hold_next       = '0;
                    last_shown_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Read address for the next cycle's tick, from the state it will hold.
    assign count_next = eff_count(aresetn ? frame_count_next : '0);
    assign sel_ahead  = shown_of(aresetn ? play_pos_next : '0, count_next,
                                 aresetn ? reverse_next : 1'b0);
    assign ram_raddr  = to_addr(sel_ahead);
    assign ram_waddr  = to_addr(fidx_ext);

    afs_ram #(
        .WIDTH (afs_pkg::HOLD_W),
        .DEPTH (MAX_FRAMES)
    ) u_interval_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_hold_ticks),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_count_reg      <= '0;
            default_interval_reg <= afs_pkg::DEFAULT_INTERVAL_RST;
            reverse_reg          <= 1'b0;
            play_pos_reg         <= '0;
            hold_reg             <= '0;
            last_shown_reg       <= '0;
            written_reg          <= '0;
            m_valid_reg          <= 1'b0;
            bypass_hit_reg       <= 1'b0;
        end else begin
            frame_count_reg <= frame_count_next;
            reverse_reg     <= reverse_next;
            if (cfg_wen && cfg_index == afs_pkg::CFG_DEFAULT_INTERVAL) begin
                default_interval_reg <= cfg_wdata[afs_pkg::HOLD_W-1:0];
            end
            play_pos_reg   <= play_pos_next;
            hold_reg       <= hold_next;
            last_shown_reg <= last_shown_next;
            if (ram_we) begin
                written_reg[ram_waddr] <= 1'b1;
            end
            bypass_hit_reg <= ram_we && (ram_waddr == ram_raddr);
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload and forwarding data need no reset.
    always_ff @(posedge aclk) begin
        bypass_data_reg <= s_hold_ticks;
        if (accept) begin
            m_shown_frame_reg <= last_shown_next;
            m_shown_valid_reg <= shown_valid_next;
            m_play_index_reg  <= play_pos_next;
            m_finished_reg    <= play_pos_next >= count_now;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_shown_frame = m_shown_frame_reg;
    assign m_shown_valid = m_shown_valid_reg;
    assign m_play_index  = m_play_index_reg;
    assign m_finished    = m_finished_reg;

endmodule

// File: sv/afs_ram.sv
// ----------------------------------------------------------------------------
// Animation frame sequencer RAM
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module afs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: test/tb_animation_frame_sequencer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Animation frame sequencer testbench
// Drives ticks, index sets, interval writes and restarts into the sequencer
// under several register settings. Every accepted item is run through a
// behavioural predictor of the frame stepping, and every result item is
// checked field by field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tb_animation_frame_sequencer;

    // Table depth of the instance, which is built with its default parameters.
    localparam int FRAME_SLOTS = 64;
    // Hold counter ceiling for a 16-bit counter.
    localparam logic [afs_pkg::HOLD_W-1:0] HOLD_CEILING = 16'hFFFF;
    // The fourth register index has no register behind it; writes are dropped.
    localparam logic [afs_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    // Cycle budget for the whole run, above the slowest legal run (every item
    // meeting a full sender gap and a full receiver stall, plus the long
    // hold-off).
    localparam int RUN_LIMIT = 400000;
    // Cycles allowed after the last result before the verdict. The block
    // answers in the cycle after it accepts an item, so this is generous.
    localparam int DRAIN_CYCLES = 8;

    // One result item as the predictor sees it.
    typedef struct packed {
        logic [afs_pkg::FIDX_W-1:0]  shown_frame;
        logic                        shown_valid;
        logic [afs_pkg::COUNT_W-1:0] play_index;
        logic                        finished;
    } frame_result_t;

    logic                          aclk;
    logic                          aresetn = 1'b0;
    logic                          cfg_wen = 1'b0;
    logic [afs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [afs_pkg::CFG_W-1:0]     cfg_wdata = '0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [afs_pkg::OP_W-1:0]      s_op = '0;
    logic [afs_pkg::FIDX_W-1:0]    s_frame_index = '0;
    logic [afs_pkg::HOLD_W-1:0]    s_hold_ticks = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [afs_pkg::FIDX_W-1:0]    m_shown_frame;
    logic                          m_shown_valid;
    logic [afs_pkg::COUNT_W-1:0]   m_play_index;
    logic                          m_finished;

    // Predictor copy of the configuration, starting at the reset values.
    logic [afs_pkg::COUNT_W-1:0] cfg_frames = '0;
    logic [afs_pkg::HOLD_W-1:0]  cfg_default_hold = afs_pkg::DEFAULT_INTERVAL_RST;
    logic                        cfg_reverse = 1'b0;

    // Predictor copy of the sequencing state.
    logic [afs_pkg::COUNT_W-1:0] play_pos = '0;
    logic [afs_pkg::HOLD_W-1:0]  hold_count = '0;
    logic [afs_pkg::HOLD_W-1:0]  hold_table [FRAME_SLOTS] = '{default: '0};
    logic                        hold_written [FRAME_SLOTS] = '{default: 1'b0};
    logic [afs_pkg::FIDX_W-1:0]  last_frame = '0;

    // Results that have been predicted but have not yet come out.
    frame_result_t pending_frames[$];
    frame_result_t oldest_frame;

    int  mismatch_count = 0;
    int  cycle_count = 0;
    // Idling switches for the sender and the receiver, and the long hold-off
    // that the receiver counts down on its own.
    bit  src_gaps = 1'b0;
    bit  sink_gaps = 1'b0;
    int  long_holdoff = 0;
    int  sink_stall_left = 0;

    animation_frame_sequencer u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_frame_index (s_frame_index),
        .s_hold_ticks  (s_hold_ticks),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_shown_frame (m_shown_frame),
        .m_shown_valid (m_shown_valid),
        .m_play_index  (m_play_index),
        .m_finished    (m_finished)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Frame count as the block uses it: anything above the table depth is
    // treated as a full table.
    function automatic int active_frames();
        return (cfg_frames > FRAME_SLOTS) ? FRAME_SLOTS : int'(cfg_frames);
    endfunction

    // Jump to a frame: the target is pulled back to the last frame (or to
    // frame 0 with an empty animation), and the counter and the shown frame
    // start afresh.
    function automatic void seek_frame(input int target);
        int count;
        count = active_frames();
        if (count == 0)
            target = 0;
        else if (target >= count)
            target = count - 1;
        play_pos = target[afs_pkg::COUNT_W-1:0];
        hold_count = '0;
        last_frame = '0;
    endfunction

    // Applies one item to the predicted state and returns the result item it
    // should produce.
    function automatic frame_result_t step_animation(
        input afs_pkg::afs_op_t op,
        input logic [afs_pkg::FIDX_W-1:0] fidx,
        input logic [afs_pkg::HOLD_W-1:0] ticks);
        int                         count;
        int                         cur;
        logic [afs_pkg::HOLD_W-1:0] interval;
        frame_result_t              res;
        count = active_frames();
        res.shown_valid = 1'b0;
        case (op)
            afs_pkg::OP_TICK: begin
                if (count != 0) begin
                    // In reverse the mirror of the play index is shown. The
                    // index may sit past the end after the count shrank, so
                    // the frame is clamped on both sides.
                    cur = cfg_reverse ? count - 1 - int'(play_pos) : int'(play_pos);
                    if (cur < 0)
                        cur = 0;
                    if (cur >= count)
                        cur = count - 1;
                    interval = hold_written[cur] ? hold_table[cur] : cfg_default_hold;
                    if (hold_count >= interval) begin
                        if (int'(play_pos) < count)
                            play_pos = play_pos + 1'b1;
                        hold_count = '0;
                    end
                    if (hold_count != HOLD_CEILING)
                        hold_count = hold_count + 1'b1;
                    last_frame = cur[afs_pkg::FIDX_W-1:0];
                    res.shown_valid = 1'b1;
                end
            end
            afs_pkg::OP_SET: begin
                seek_frame(int'(fidx));
            end
            afs_pkg::OP_WRITE: begin
                // Every 6-bit entry index lies inside the 64-entry table.
                hold_table[fidx] = ticks;
                hold_written[fidx] = 1'b1;
            end
            default: begin
                seek_frame(0);
            end
        endcase
        res.shown_frame = last_frame;
        res.play_index = play_pos;
        res.finished = (int'(play_pos) >= count);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("ERROR at %0t: %s got %0d, expected %0d", $time, what, got, want);
    endtask

    // Results are checked before the item accepted on the same edge is
    // predicted, so a result can never be matched with its own item.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_frames.size() == 0) begin
                    report_mismatch("result item with nothing expected", 0, 0);
                end else begin
                    oldest_frame = pending_frames.pop_front();
                    if (m_shown_frame !== oldest_frame.shown_frame)
                        report_mismatch("shown_frame", int'(m_shown_frame),
                                        int'(oldest_frame.shown_frame));
                    if (m_shown_valid !== oldest_frame.shown_valid)
                        report_mismatch("shown_valid", int'(m_shown_valid),
                                        int'(oldest_frame.shown_valid));
                    if (m_play_index !== oldest_frame.play_index)
                        report_mismatch("play_index", int'(m_play_index),
                                        int'(oldest_frame.play_index));
                    if (m_finished !== oldest_frame.finished)
                        report_mismatch("finished", int'(m_finished),
                                        int'(oldest_frame.finished));
                end
            end
            if (s_valid && s_ready)
                pending_frames.push_back(step_animation(afs_pkg::afs_op_t'(s_op),
                                                        s_frame_index, s_hold_ticks));
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("animation_frame_sequencer verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver
    // ------------------------------------------------------------------------

    // The receiver stalls in random bursts when allowed to, and honours a
    // requested long hold-off by counting it down itself. Exactly one
    // assignment to m_ready is made per falling edge.
    initial begin
        forever begin
            @(negedge aclk);
            if (long_holdoff > 0) begin
                m_ready <= 1'b0;
                long_holdoff--;
            end else if (sink_stall_left > 0) begin
                m_ready <= 1'b0;
                sink_stall_left--;
            end else if (sink_gaps && $urandom_range(0, 6) == 0) begin
                m_ready <= 1'b0;
                sink_stall_left = $urandom_range(1, 19) - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender and register access
    // ------------------------------------------------------------------------

    // Offers one item and returns on the rising edge at which it is taken.
    // The caller either offers the next item at the following falling edge,
    // so valid stays high without a glitch, or calls a task that drops it.
    task automatic send_item(input afs_pkg::afs_op_t op,
                             input logic [afs_pkg::FIDX_W-1:0] fidx,
                             input logic [afs_pkg::HOLD_W-1:0] ticks);
        int gap;
        @(negedge aclk);
        if (src_gaps && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_frame_index <= fidx;
        s_hold_ticks <= ticks;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // Stops offering items and waits until every predicted result has been
    // taken. Every item yields a result, so an empty queue means the block
    // is idle.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(negedge aclk);
    endtask

    // Writes one register. Only called while the block is idle, so the
    // predictor's copy is updated straight away.
    task automatic cfg_write(input logic [afs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [afs_pkg::CFG_W-1:0] data);
        @(negedge aclk);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_wen <= 1'b0;
        case (idx)
            afs_pkg::CFG_FRAME_COUNT:      cfg_frames = data[afs_pkg::COUNT_W-1:0];
            afs_pkg::CFG_DEFAULT_INTERVAL: cfg_default_hold = data;
            afs_pkg::CFG_REVERSE_PLAYBACK: cfg_reverse = data[0];
            default: ;
        endcase
    endtask

    // One random item, mostly ticks so that playback gets to the end of the
    // animation, with frame indexes mostly inside the active frames.
    task automatic send_random_item(input int span);
        int                         pick;
        afs_pkg::afs_op_t           op;
        logic [afs_pkg::FIDX_W-1:0] fidx;
        logic [afs_pkg::HOLD_W-1:0] ticks;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            op = afs_pkg::OP_TICK;
        else if (pick < 88)
            op = afs_pkg::OP_WRITE;
        else if (pick < 94)
            op = afs_pkg::OP_SET;
        else
            op = afs_pkg::OP_RESTART;
        if (span == 0 || $urandom_range(0, 3) == 0)
            fidx = afs_pkg::FIDX_W'($urandom_range(0, FRAME_SLOTS - 1));
        else
            fidx = afs_pkg::FIDX_W'($urandom_range(0, span - 1));
        if ($urandom_range(0, 7) == 0)
            ticks = afs_pkg::HOLD_W'($urandom_range(0, 65535));
        else
            ticks = afs_pkg::HOLD_W'($urandom_range(0, 5));
        send_item(op, fidx, ticks);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // With the reset settings the animation is empty: a tick shows nothing and
    // moves nothing, a set lands on frame 0, and the play index counts as
    // finished throughout. A write to the unused register index is dropped.
    task automatic test_empty_animation();
        cfg_write(CFG_SPARE, 16'hFFFF);
        send_item(afs_pkg::OP_TICK, 6'd0, 16'd0);
        send_item(afs_pkg::OP_SET, 6'd37, 16'd0);
        send_item(afs_pkg::OP_WRITE, 6'd0, 16'd0);
        send_item(afs_pkg::OP_RESTART, 6'd63, 16'hFFFF);
        send_item(afs_pkg::OP_TICK, 6'd63, 16'hFFFF);
        wait_idle();
    endtask

    // Three frames played forwards with a zero default interval: the index
    // moves on each tick, saturates at the count, and a set past the end is
    // pulled back to the last frame. The frame count is written with junk in
    // the upper bits, which the register must drop.
    task automatic test_forward_edges();
        cfg_write(afs_pkg::CFG_FRAME_COUNT, 16'hFF83);
        cfg_write(afs_pkg::CFG_DEFAULT_INTERVAL, 16'd0);
        repeat (5) send_item(afs_pkg::OP_TICK, 6'd0, 16'd0);
        send_item(afs_pkg::OP_SET, 6'd63, 16'd0);
        send_item(afs_pkg::OP_TICK, 6'd0, 16'd0);
        send_item(afs_pkg::OP_WRITE, 6'd1, 16'hFFFF);
        send_item(afs_pkg::OP_RESTART, 6'd0, 16'd0);
        repeat (2) send_item(afs_pkg::OP_TICK, 6'd0, 16'd0);
        wait_idle();
    endtask

    // Reverse playback on a count above the table depth, which acts as a full
    // table. Then the count shrinks under a play index past the end, so the
    // mirrored frame clamps at the bottom and the forward frame at the top.
    task automatic test_reverse_and_clamp();
        cfg_write(afs_pkg::CFG_FRAME_COUNT, 16'd127);
        cfg_write(afs_pkg::CFG_DEFAULT_INTERVAL, 16'hFFFF);
        cfg_write(afs_pkg::CFG_REVERSE_PLAYBACK, 16'hFFFF);
        send_item(afs_pkg::OP_SET, 6'd63, 16'd0);
        send_item(afs_pkg::OP_TICK, 6'd0, 16'd0);
        send_item(afs_pkg::OP_TICK, 6'd0, 16'd0);
        send_item(afs_pkg::OP_WRITE, 6'd63, 16'd0);
        wait_idle();
        cfg_write(afs_pkg::CFG_FRAME_COUNT, 16'd2);
        send_item(afs_pkg::OP_TICK, 6'd0, 16'd0);
        wait_idle();
        cfg_write(afs_pkg::CFG_REVERSE_PLAYBACK, 16'd0);
        send_item(afs_pkg::OP_TICK, 6'd0, 16'd0);
        send_item(afs_pkg::OP_RESTART, 6'd0, 16'd0);
        wait_idle();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering, so the result register fills and the input stalls. Then the
    // sender stops until every result has come back.
    task automatic test_backpressure();
        cfg_write(afs_pkg::CFG_FRAME_COUNT, 16'd6);
        cfg_write(afs_pkg::CFG_DEFAULT_INTERVAL, 16'd1);
        long_holdoff = 250;
        send_item(afs_pkg::OP_RESTART, 6'd0, 16'd0);
        repeat (30) send_random_item(6);
        wait_idle();
    endtask

    // Phases of random play. Each phase picks a setting, writes a few hold
    // intervals, restarts and then plays a random mix. Counts are mostly
    // small so that animations run to their end, with the empty, full and
    // oversized counts mixed in.
    task automatic test_random_playback(input int phases, input int items_per_phase,
                                        input bit with_idling);
        int                        ph;
        int                        n;
        int                        span;
        int                        writes;
        logic [afs_pkg::CFG_W-1:0] data;
        for (ph = 0; ph < phases; ph++) begin
            wait_idle();
            // Some phases run without idling even when idling is allowed.
            src_gaps = with_idling && ($urandom_range(0, 3) != 0);
            sink_gaps = with_idling && ($urandom_range(0, 3) != 0);
            data = afs_pkg::CFG_W'($urandom);
            case ($urandom_range(0, 9))
                0:       data[afs_pkg::COUNT_W-1:0] = 7'd0;
                1:       data[afs_pkg::COUNT_W-1:0] = 7'd64;
                2:       data[afs_pkg::COUNT_W-1:0] =
                             afs_pkg::COUNT_W'($urandom_range(65, 127));
                default: data[afs_pkg::COUNT_W-1:0] =
                             afs_pkg::COUNT_W'($urandom_range(1, 8));
            endcase
            cfg_write(afs_pkg::CFG_FRAME_COUNT, data);
            if ($urandom_range(0, 5) == 0)
                data = afs_pkg::CFG_W'($urandom);
            else
                data = afs_pkg::CFG_W'($urandom_range(0, 4));
            cfg_write(afs_pkg::CFG_DEFAULT_INTERVAL, data);
            cfg_write(afs_pkg::CFG_REVERSE_PLAYBACK, afs_pkg::CFG_W'($urandom));
            if ($urandom_range(0, 3) == 0)
                cfg_write(CFG_SPARE, afs_pkg::CFG_W'($urandom));
            span = active_frames();
            writes = $urandom_range(0, 6);
            for (n = 0; n < writes; n++)
                send_item(afs_pkg::OP_WRITE,
                          (span == 0) ? afs_pkg::FIDX_W'($urandom)
                                      : afs_pkg::FIDX_W'($urandom_range(0, span - 1)),
                          ($urandom_range(0, 5) == 0) ? afs_pkg::HOLD_W'($urandom)
                                                      : afs_pkg::HOLD_W'($urandom_range(0, 4)));
            send_item(afs_pkg::OP_RESTART, afs_pkg::FIDX_W'($urandom),
                      afs_pkg::HOLD_W'($urandom));
            for (n = writes + 1; n < items_per_phase; n++)
                send_random_item(span);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------------

    initial begin
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_animation();
        test_forward_edges();
        test_reverse_and_clamp();
        src_gaps = 1'b1;
        sink_gaps = 1'b1;
        test_backpressure();
        test_random_playback(10, 100, 1'b1);
        // The closing stretch runs flat out on both sides.
        test_random_playback(4, 100, 1'b0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_frames.size() == 0)
            $display("animation_frame_sequencer verification clean");
        else
            $display("animation_frame_sequencer verification failed");
        $finish;
    end

endmodule
